>>> rtl/core/mbd_pkg.sv
package mbd_pkg;

  localparam int WIDTH_W  = 12;
  localparam int HEIGHT_W = 16;
  localparam int CFG_W    = 16;
  localparam int CH_W     = 8;
  localparam int SUM_W    = CH_W + 1;

  typedef enum logic [0:0] {
    REG_SOURCE_WIDTH  = 1'b0,
    REG_SOURCE_HEIGHT = 1'b1
  } reg_idx_t;

  // red in the low bits, as on the stream
  typedef struct packed {
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] red;
  } pixel_t;

  typedef struct packed {
    logic [SUM_W-1:0] blue;
    logic [SUM_W-1:0] green;
    logic [SUM_W-1:0] red;
  } pair_t;

  // one block result in flight from the front end to the averaging stage
  typedef struct packed {
    logic  last;
    pair_t pair;
  } job_t;

  localparam int PIXEL_W = $bits(pixel_t);
  localparam int PAIR_W  = $bits(pair_t);

endpackage

>>> rtl/core/mipmap_box_downsample.sv
// The block average of an odd-row, odd-column pixel reaches out_tvalid through
// the line-store read and the stage-1 register, then through the output register.
// Throughput: one pixel word per clock; input stalls only while the averaging
// stage and the output register are both full and out_tready is low.
// Reset (rst_n, synchronous): sizes, counters, held pixel and valid flags clear.
// The line store is not cleared; odd rows read only slots of the row before.
module mipmap_box_downsample #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [mbd_pkg::PIXEL_W-1:0] in_tdata,   // red, green, blue
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [mbd_pkg::PIXEL_W-1:0] out_tdata,  // out_red, out_green, out_blue
  output logic                        out_tlast,  // last_of_image
  input  logic                        cfg_we,
  input  logic [0:0]                  cfg_index,
  input  logic [mbd_pkg::CFG_W-1:0]   cfg_wdata
);

  localparam int PAIR_DEPTH = MAX_WIDTH / 2;
  localparam int AW         = $clog2(PAIR_DEPTH);

  logic            accept;
  logic            take_ok;
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  mbd_pkg::pair_t  mem_wdata;
  logic            mem_re;
  logic [AW-1:0]   mem_raddr;
  logic [mbd_pkg::PAIR_W-1:0] mem_rdata;
  logic            issue;
  mbd_pkg::job_t   job;
  mbd_pkg::pixel_t out_pixel;

  assign in_tready = take_ok;
  assign accept    = in_tvalid && take_ok;

  mbd_ctrl #(
    .MAX_WIDTH (MAX_WIDTH),
    .AW        (AW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .accept    (accept),
    .pixel     (mbd_pkg::pixel_t'(in_tdata)),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .issue     (issue),
    .job       (job)
  );

  mbd_ram #(
    .WIDTH (mbd_pkg::PAIR_W),
    .DEPTH (PAIR_DEPTH)
  ) u_line (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  mbd_avg u_avg (
    .clk        (clk),
    .rst_n      (rst_n),
    .issue      (issue),
    .job        (job),
    .rdata      (mbd_pkg::pair_t'(mem_rdata)),
    .out_tready (out_tready),
    .take_ok    (take_ok),
    .out_valid  (out_tvalid),
    .out_pixel  (out_pixel),
    .out_last   (out_tlast)
  );

  assign out_tdata = out_pixel;

endmodule

>>> rtl/core/mbd_ram.sv
module mbd_ram #(
  parameter int WIDTH = 27,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/mbd_ctrl.sv
module mbd_ctrl #(
  parameter int MAX_WIDTH = 2048,
  parameter int AW        = 10
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [0:0]                 cfg_index,
  input  logic [mbd_pkg::CFG_W-1:0]  cfg_wdata,
  input  logic                       accept,
  input  mbd_pkg::pixel_t            pixel,
  output logic                       mem_we,
  output logic [AW-1:0]              mem_waddr,
  output mbd_pkg::pair_t             mem_wdata,
  output logic                       mem_re,
  output logic [AW-1:0]              mem_raddr,
  output logic                       issue,
  output mbd_pkg::job_t              job
);

  logic [mbd_pkg::WIDTH_W-1:0]  width_r, width_nxt;
  logic [mbd_pkg::HEIGHT_W-1:0] height_r, height_nxt;
  logic [mbd_pkg::WIDTH_W-1:0]  col_r, col_nxt;
  logic [mbd_pkg::HEIGHT_W-1:0] row_r, row_nxt;
  mbd_pkg::pixel_t              left_r, left_nxt;

  logic           usable;
  logic           col_end;
  logic           row_end;
  logic [AW-1:0]  slot;
  mbd_pkg::pair_t pair;

  assign usable = (width_r >= 12'd4) && (height_r >= 16'd4) &&
                  !width_r[0] && !height_r[0] &&
                  (32'(width_r) <= 32'(MAX_WIDTH));

  assign col_end = (col_r == width_r - 12'd1);
  assign row_end = (row_r == height_r - 16'd1);
  assign slot    = AW'(col_r >> 1);

  assign pair.red   = {1'b0, left_r.red}   + {1'b0, pixel.red};
  assign pair.green = {1'b0, left_r.green} + {1'b0, pixel.green};
  assign pair.blue  = {1'b0, left_r.blue}  + {1'b0, pixel.blue};

  // even row stores the pair sum; odd row fetches it one row later, so the
  // write and the read of a slot are always at least a row apart
  assign mem_we    = accept && usable && col_r[0] && !row_r[0];
  assign mem_waddr = slot;
  assign mem_wdata = pair;
  assign mem_re    = accept && usable && col_r[0] && row_r[0];
  assign mem_raddr = slot;

  assign issue     = mem_re;
  assign job.pair  = pair;
  assign job.last  = row_end && col_end;

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    col_nxt    = col_r;
    row_nxt    = row_r;
    left_nxt   = left_r;
    if (cfg_we) begin
      unique case (mbd_pkg::reg_idx_t'(cfg_index))
        mbd_pkg::REG_SOURCE_WIDTH:  width_nxt  = cfg_wdata[mbd_pkg::WIDTH_W-1:0];
        mbd_pkg::REG_SOURCE_HEIGHT: height_nxt = cfg_wdata[mbd_pkg::HEIGHT_W-1:0];
        default: ;
      endcase
      col_nxt = '0;
      row_nxt = '0;
    end else if (accept) begin
      if (!usable) begin
        col_nxt = '0;
        row_nxt = '0;
      end else begin
        if (!col_r[0]) begin
          left_nxt = pixel;
        end
        if (col_end) begin
          col_nxt = '0;
          row_nxt = row_end ? '0 : row_r + 16'd1;
        end else begin
          col_nxt = col_r + 12'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= '0;
      height_r <= '0;
      col_r    <= '0;
      row_r    <= '0;
      left_r   <= '0;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      left_r   <= left_nxt;
    end
  end

endmodule

>>> rtl/core/mbd_avg.sv
module mbd_avg (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            issue,
  input  mbd_pkg::job_t   job,
  input  mbd_pkg::pair_t  rdata,
  input  logic            out_tready,
  output logic            take_ok,
  output logic            out_valid,
  output mbd_pkg::pixel_t out_pixel,
  output logic            out_last
);

  logic            s1_valid_r, s1_valid_nxt;
  mbd_pkg::job_t   s1_job_r;
  logic            out_valid_r, out_valid_nxt;
  mbd_pkg::pixel_t out_pixel_r;
  logic            out_last_r;
  logic            advance;
  logic [mbd_pkg::SUM_W:0] sum_red, sum_green, sum_blue;
  mbd_pkg::pixel_t avg;

  assign advance = !out_valid_r || out_tready;
  assign take_ok = !s1_valid_r || advance;

  // rdata holds while stage 1 waits: no read is issued until it moves on
  assign sum_red   = {1'b0, rdata.red}   + {1'b0, s1_job_r.pair.red};
  assign sum_green = {1'b0, rdata.green} + {1'b0, s1_job_r.pair.green};
  assign sum_blue  = {1'b0, rdata.blue}  + {1'b0, s1_job_r.pair.blue};
  assign avg.red   = sum_red[mbd_pkg::SUM_W:2];
  assign avg.green = sum_green[mbd_pkg::SUM_W:2];
  assign avg.blue  = sum_blue[mbd_pkg::SUM_W:2];

  always_comb begin
    s1_valid_nxt  = s1_valid_r;
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = s1_valid_r;
      s1_valid_nxt  = 1'b0;
    end
    if (issue) begin
      s1_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (issue) begin
      s1_job_r <= job;
    end
    if (advance && s1_valid_r) begin
      out_pixel_r <= avg;
      out_last_r  <= s1_job_r.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_pixel = out_pixel_r;
  assign out_last  = out_last_r;

  a_issue_room: assert property (@(posedge clk) disable iff (!rst_n)
    issue |-> take_ok)
    else $error("block issued with stage 1 full and output stalled");

  a_s1_moves: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && advance |=> out_valid_r)
    else $error("stage 1 word lost on its way to the output");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !s1_valid_r && !out_valid_r)
    else $error("pipeline not empty after reset");

endmodule
